### sv/knapsack_01_solver_top_defines.svh
// Assertion macros shared by the knapsack solver RTL.
`ifndef KNAPSACK_01_SOLVER_TOP_DEFINES_SVH
`define KNAPSACK_01_SOLVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KS01_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KS01_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ks01_pkg.sv
// Constants, payload types and helper functions of the 0/1 knapsack solver.
package ks01_pkg;

    localparam int MAX_ITEMS    = 16;
    localparam int MAX_CAPACITY = 255;
    localparam int RESULT_LIMIT = 16;

    localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int COL_W   = $clog2(MAX_CAPACITY + 1);
    localparam int JW      = (COL_W > 8) ? COL_W : 8;
    localparam int FOUND_W = $clog2(RESULT_LIMIT + 1);
    localparam int SUM_W   = 24;

    // Register file: one register, word addressed by paddr[ADDR_W-1:2]
    localparam int ADDR_W = 3;
    localparam int REG_W  = ADDR_W - 2;
    localparam logic [REG_W-1:0] REG_CAPACITY = '0;
    localparam logic [7:0] CAPACITY_RESET = 8'd100;

    typedef struct packed {
        logic [7:0]  item_weight;
        logic [19:0] item_value;
        logic        last_item;
    } req_t;

    typedef struct packed {
        logic [3:0]       item_index;
        logic [7:0]       chosen_weight;
        logic [19:0]      chosen_value;
        logic [SUM_W-1:0] total_value;
        logic             none_chosen;
        logic             last_result;
    } res_t;

    // Saturating add of an item value onto a best-value sum
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [19:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // Clamp the configured capacity to the table width
    function automatic logic [COL_W-1:0] eff_cap(input logic [7:0] c);
        if (32'(c) > 32'(MAX_CAPACITY))
            return COL_W'(MAX_CAPACITY);
        return COL_W'(c);
    endfunction

endpackage

### sv/knapsack_01_solver_top.sv
// 0/1 knapsack solver: item loader, DP over a best-value memory, trace-back.
`include "knapsack_01_solver_top_defines.svh"

// Items are loaded one per cycle while busy is low. A request with last_item
// set raises busy and starts the solve for c = min(capacity, 255): a sweep
// clears columns 0 to c of the best-value memory, then each of the n loaded
// items takes one DP column per cycle from c down to 0 through the two-read,
// one-write best-value memory, plus a gap state to let the last write land,
// then the trace-back walks the items from the last one down (take-bit
// memory read, then evaluate) and ends in a flush state. Results come
// out on result with result_valid high for exactly one cycle each; the
// receiver cannot stall them, so it must take every strobe. The last result
// of a run carries last_result; a run that chooses nothing gives one result
// with none_chosen set. A new set may be loaded once busy falls.
module knapsack_01_solver_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ks01_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  ks01_pkg::req_t               item,
    output logic                         result_valid,
    output ks01_pkg::res_t               result
);

    localparam int IDX_W     = ks01_pkg::IDX_W;
    localparam int CNT_W     = ks01_pkg::CNT_W;
    localparam int COL_W     = ks01_pkg::COL_W;
    localparam int JW        = ks01_pkg::JW;
    localparam int FOUND_W   = ks01_pkg::FOUND_W;
    localparam int SUM_W     = ks01_pkg::SUM_W;
    localparam int TAKE_AW   = IDX_W + COL_W;
    localparam int ADDR_W_HI = ks01_pkg::ADDR_W - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DP,
        S_GAP,
        S_TB_RD,
        S_TB_EV,
        S_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [7:0]             cap_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       item_reg, item_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [COL_W-1:0]       ecap_reg, ecap_next;
    logic                   p_valid_reg, p_valid_next;
    logic [COL_W-1:0]       p_col_reg, p_col_next;
    logic                   p_fit_reg, p_fit_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic [FOUND_W-1:0]     found_reg, found_next;
    ks01_pkg::res_t         pend_reg, pend_next;
    logic                   res_valid_reg, res_valid_next;
    ks01_pkg::res_t         res_reg, res_next;

    // Item store
    logic [7:0]             weight_store_reg [ks01_pkg::MAX_ITEMS];
    logic [19:0]            value_store_reg  [ks01_pkg::MAX_ITEMS];

    // Best-value row and take-bit table
    logic [SUM_W-1:0]       best_mem [1 << COL_W];
    logic                   take_mem [1 << TAKE_AW];
    logic [SUM_W-1:0]       best_a_reg, best_b_reg;
    logic                   take_rd_reg;

    logic                   accept;
    logic                   store_ok;
    logic [7:0]             cur_w;
    logic [19:0]            cur_v;
    logic                   fit;
    logic [SUM_W-1:0]       cand;
    logic [SUM_W-1:0]       tb_total;
    logic                   dp_take;
    logic [COL_W-1:0]       br_addr_a, br_addr_b;
    logic                   bw_en;
    logic [COL_W-1:0]       bw_addr;
    logic [SUM_W-1:0]       bw_data;
    logic                   tw_en;
    logic [TAKE_AW-1:0]     tw_addr;
    logic                   tw_data;
    logic [TAKE_AW-1:0]     tr_addr;
    logic                   cfg_write;

    assign accept    = start && (state_reg == S_IDLE);
    assign store_ok  = (count_reg < CNT_W'(ks01_pkg::MAX_ITEMS));
    assign cur_w     = weight_store_reg[item_reg];
    assign cur_v     = value_store_reg[item_reg];
    assign fit       = (JW'(col_reg) >= JW'(cur_w));
    assign cand      = ks01_pkg::sat_add(best_b_reg, cur_v);
    assign dp_take   = p_fit_reg && (cand > best_a_reg);
    assign tb_total  = ks01_pkg::sat_add(total_reg, cur_v);
    assign br_addr_a = col_reg;
    assign br_addr_b = col_reg - COL_W'(cur_w);
    assign tr_addr   = {item_reg, col_reg};
    assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W_HI:2] == ks01_pkg::REG_CAPACITY);

    // Best-value memory ports: clear sweep, or DP write-back stage
    always_comb
    begin
        bw_en   = 1'b0;
        bw_addr = p_col_reg;
        bw_data = cand;
        if (state_reg == S_CLEAR)
        begin
            bw_en   = 1'b1;
            bw_addr = col_reg;
            bw_data = '0;
        end
        else if (p_valid_reg)
        begin
            bw_en = dp_take;
        end
    end

    // Take-bit write for every DP column
    assign tw_en   = p_valid_reg;
    assign tw_addr = {item_reg, p_col_reg};
    assign tw_data = dp_take;

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        item_next      = item_reg;
        col_next       = col_reg;
        ecap_next      = ecap_reg;
        p_valid_next   = 1'b0;
        p_col_next     = col_reg;
        p_fit_next     = fit;
        total_next     = total_reg;
        found_next     = found_reg;
        pend_next      = pend_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (store_ok)
                        count_next = count_reg + 1'b1;
                    if (item.last_item)
                    begin
                        n_next     = store_ok ? count_reg + 1'b1 : count_reg;
                        count_next = '0;
                        ecap_next  = ks01_pkg::eff_cap(cap_reg);
                        col_next   = '0;
                        item_next  = '0;
                        total_next = '0;
                        found_next = '0;
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                if (col_reg == ecap_reg)
                begin
                    col_next   = ecap_reg;
                    state_next = (n_reg == '0) ? S_FLUSH : S_DP;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_DP:
            begin
                p_valid_next = 1'b1;
                if (col_reg == '0)
                    state_next = S_GAP;
                else
                    col_next = col_reg - 1'b1;
            end
            S_GAP:
            begin
                // let the column-zero write land before the next item reads
                col_next = ecap_reg;
                if (item_reg == IDX_W'(n_reg - 1'b1))
                begin
                    state_next = S_TB_RD;
                end
                else
                begin
                    item_next  = item_reg + 1'b1;
                    state_next = S_DP;
                end
            end
            S_TB_RD:
            begin
                state_next = S_TB_EV;
            end
            S_TB_EV:
            begin
                if (take_rd_reg)
                begin
                    total_next               = tb_total;
                    found_next               = found_reg + 1'b1;
                    pend_next.item_index     = 4'(item_reg);
                    pend_next.chosen_weight  = cur_w;
                    pend_next.chosen_value   = cur_v;
                    pend_next.total_value    = tb_total;
                    pend_next.none_chosen    = 1'b0;
                    pend_next.last_result    = 1'b0;
                    col_next                 = col_reg - COL_W'(cur_w);
                    // release the previous pick now that another follows
                    if (found_reg != '0)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = pend_reg;
                    end
                end
                if ((item_reg == '0) ||
                    (take_rd_reg && (found_reg == FOUND_W'(ks01_pkg::RESULT_LIMIT - 1))))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    item_next  = item_reg - 1'b1;
                    state_next = S_TB_RD;
                end
            end
            S_FLUSH:
            begin
                res_valid_next = 1'b1;
                if (found_reg != '0)
                begin
                    res_next             = pend_reg;
                    res_next.last_result = 1'b1;
                end
                else
                begin
                    res_next             = '0;
                    res_next.none_chosen = 1'b1;
                    res_next.last_result = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, configuration and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= ks01_pkg::CAPACITY_RESET;
            count_reg     <= '0;
            p_valid_reg   <= 1'b0;
            found_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            p_valid_reg   <= p_valid_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            if (cfg_write)
                cap_reg <= pwdata[7:0];
        end
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        item_reg  <= item_next;
        col_reg   <= col_next;
        ecap_reg  <= ecap_next;
        p_col_reg <= p_col_next;
        p_fit_reg <= p_fit_next;
        total_reg <= total_next;
        pend_reg  <= pend_next;
    end

    // Store the incoming item while there is room
    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            weight_store_reg[IDX_W'(count_reg)] <= item.item_weight;
            value_store_reg[IDX_W'(count_reg)]  <= item.item_value;
        end
    end

    // Best-value memory: two reads, one write
    always_ff @(posedge clk)
    begin
        if (bw_en)
            best_mem[bw_addr] <= bw_data;
        best_a_reg <= best_mem[br_addr_a];
        best_b_reg <= best_mem[br_addr_b];
    end

    // Take-bit memory: one read, one write
    always_ff @(posedge clk)
    begin
        if (tw_en)
            take_mem[tw_addr] <= tw_data;
        take_rd_reg <= take_mem[tr_addr];
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[ADDR_W_HI:2] == ks01_pkg::REG_CAPACITY) ? 32'(cap_reg) : '0;

    `KS01_ASSERT_NEXT(a_last_starts_solve, accept && item.last_item, busy, "solve did not start")
    `KS01_ASSERT_IMPLY(a_dp_stage_in_dp, p_valid_reg, (state_reg == S_DP) || (state_reg == S_GAP), "DP write-back outside DP")
    `KS01_ASSERT_IMPLY(a_best_write_fits, p_valid_reg && bw_en, p_fit_reg, "best value written for a column that does not fit")
    `KS01_ASSERT_IMPLY(a_none_is_last, result_valid && result.none_chosen, result.last_result && (result.total_value == '0), "empty result malformed")
    `KS01_ASSERT_IMPLY(a_found_bound, 1'b1, found_reg <= FOUND_W'(ks01_pkg::RESULT_LIMIT), "result count overrun")

endmodule

### tb/sv/knapsack_01_solver_top_test.sv
// Self-checking testbench for the 0/1 knapsack solver: directed sets, then random sets.
`timescale 1ns / 1ps

module knapsack_01_solver_top_test;

    localparam logic [ks01_pkg::ADDR_W-1:0] CAPACITY_ADDR = {ks01_pkg::REG_CAPACITY, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ks01_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    ks01_pkg::req_t item;
    logic        result_valid;
    ks01_pkg::res_t result;

    // Local copy of the solver state
    logic [7:0]  cap_setting;
    logic [7:0]  stored_weight [0:ks01_pkg::MAX_ITEMS-1];
    logic [19:0] stored_value [0:ks01_pkg::MAX_ITEMS-1];
    int          stored_count;

    // Picks still owed by the solver, oldest first
    ks01_pkg::res_t expected_picks [$];

    int n_errors;
    int n_requests;
    int n_solves;
    int n_results;
    int n_settings;

    knapsack_01_solver_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    // Generate a 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Add a value onto a 24-bit sum, clamping at all ones
    function automatic logic [23:0] sum_clamp(input logic [23:0] a, input logic [19:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {5'b0, b};
        return s[24] ? 24'hFFFFFF : s[23:0];
    endfunction

    // Solve the stored set and queue the picks in trace-back order
    function automatic void predict_selection();
        logic [23:0] best [0:ks01_pkg::MAX_CAPACITY];
        bit          took [0:ks01_pkg::MAX_ITEMS-1][0:ks01_pkg::MAX_CAPACITY];
        logic [23:0] cand;
        logic [23:0] total;
        ks01_pkg::res_t pick;
        int          cap;
        int          col;
        int          picks;
        cap = (int'(cap_setting) > ks01_pkg::MAX_CAPACITY) ? ks01_pkg::MAX_CAPACITY
                                                            : int'(cap_setting);
        for (int j = 0; j <= ks01_pkg::MAX_CAPACITY; j++)
            best[j] = '0;
        // fill the best-value row item by item, high columns first
        for (int i = 0; i < stored_count; i++)
        begin
            for (int j = cap; j >= 0; j--)
            begin
                took[i][j] = 1'b0;
                if (j >= int'(stored_weight[i]))
                begin
                    cand = sum_clamp(best[j - int'(stored_weight[i])], stored_value[i]);
                    // take only on a strict gain
                    if (cand > best[j])
                    begin
                        best[j] = cand;
                        took[i][j] = 1'b1;
                    end
                end
            end
        end
        // walk back from the last stored item; zero weights keep the column
        col = cap;
        total = '0;
        picks = 0;
        for (int i = stored_count - 1; i >= 0 && picks < ks01_pkg::RESULT_LIMIT; i--)
        begin
            if (took[i][col])
            begin
                total = sum_clamp(total, stored_value[i]);
                pick.item_index    = 4'(i);
                pick.chosen_weight = stored_weight[i];
                pick.chosen_value  = stored_value[i];
                pick.total_value   = total;
                pick.none_chosen   = 1'b0;
                pick.last_result   = 1'b0;
                expected_picks.push_back(pick);
                picks++;
                col -= int'(stored_weight[i]);
            end
        end
        if (picks == 0)
        begin
            pick = '0;
            pick.none_chosen = 1'b1;
            pick.last_result = 1'b1;
            expected_picks.push_back(pick);
        end
        else
            expected_picks[expected_picks.size() - 1].last_result = 1'b1;
    endfunction

    // Update the local state for one accepted request
    function automatic void absorb_request(input ks01_pkg::req_t req);
        n_requests++;
        if (stored_count < ks01_pkg::MAX_ITEMS)
        begin
            stored_weight[stored_count] = req.item_weight;
            stored_value[stored_count]  = req.item_value;
            stored_count++;
        end
        if (req.last_item)
        begin
            predict_selection();
            n_solves++;
            stored_count = 0;
        end
    endfunction

    // Send one request, with an optional idle gap first; leaves start high
    task automatic send_request(input ks01_pkg::req_t req, input int gap_pct);
        int gap;
        if (int'($urandom_range(99)) < gap_pct)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= req;
        do
            @(posedge clk);
        while (busy);
        absorb_request(req);
        @(negedge clk);
    endtask

    // Drop start and hold until every pick has arrived and the solver is idle
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (expected_picks.size() != 0 || busy);
    endtask

    // One APB transfer: setup cycle, access cycle, then release the bus
    task automatic apb_transfer(input bit wr, input logic [ks01_pkg::ADDR_W-1:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_capacity_reg();
        logic [31:0] rd;
        apb_transfer(1'b0, CAPACITY_ADDR, '0, rd);
        if (rd[7:0] !== cap_setting)
            report_mismatch($sformatf("capacity read 0x%0h, expected 0x%0h",
                                      rd[7:0], cap_setting));
    endtask

    // Write a new capacity while idle and read it back
    task automatic set_capacity(input logic [7:0] cap);
        logic [31:0] rd;
        wait_drained();
        apb_transfer(1'b1, CAPACITY_ADDR, {24'b0, cap}, rd);
        cap_setting = cap;
        n_settings++;
        check_capacity_reg();
    endtask

    function automatic ks01_pkg::req_t make_req(input logic [7:0] w, input logic [19:0] v,
                                                input logic last);
        ks01_pkg::req_t r;
        r.item_weight = w;
        r.item_value  = v;
        r.last_item   = last;
        return r;
    endfunction

    // Compare one result field
    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Check each strobed result against the oldest pending pick
    always @(posedge clk)
    begin
        ks01_pkg::res_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_picks.size() == 0)
                report_mismatch("result with no pick pending");
            else
            begin
                want = expected_picks.pop_front();
                n_results++;
                check_field("item_index", 32'(result.item_index), 32'(want.item_index));
                check_field("chosen_weight", 32'(result.chosen_weight),
                            32'(want.chosen_weight));
                check_field("chosen_value", 32'(result.chosen_value),
                            32'(want.chosen_value));
                check_field("total_value", 32'(result.total_value), 32'(want.total_value));
                check_field("none_chosen", 32'(result.none_chosen), 32'(want.none_chosen));
                check_field("last_result", 32'(result.last_result), 32'(want.last_result));
            end
        end
    end

    // Reset value of the capacity register
    task automatic test_capacity_reset();
        check_capacity_reg();
    endtask

    // Nothing fits: an oversized item and a zero-value item
    task automatic test_nothing_fits();
        send_request(make_req(8'd255, 20'hFFFFF, 1'b0), 0);
        send_request(make_req(8'd1, 20'd0, 1'b1), 0);
    endtask

    // Equal items: both fit together, so both are taken
    task automatic test_tie();
        send_request(make_req(8'd10, 20'd500, 1'b0), 0);
        send_request(make_req(8'd10, 20'd500, 1'b1), 0);
    endtask

    // Zero-weight items at zero capacity are all picked up on the way back
    task automatic test_zero_weight();
        set_capacity(8'd0);
        send_request(make_req(8'd0, 20'd5, 1'b0), 0);
        send_request(make_req(8'd3, 20'd9, 1'b0), 0);
        send_request(make_req(8'd0, 20'hFFFFF, 1'b1), 0);
    endtask

    // Full store: sixteen picks, then a dropped request that still starts the solve
    task automatic test_full_store();
        set_capacity(8'd255);
        for (int i = 0; i < ks01_pkg::MAX_ITEMS; i++)
            send_request(make_req(8'd15, 20'hFFFFF - 20'(i * 4099), 1'b0), 0);
        send_request(make_req(8'd255, 20'hFFFFF, 1'b1), 0);
    endtask

    // Random sets under several capacities and idle patterns
    task automatic test_random_sets();
        int   gap_pcts [6];
        int   caps [6];
        int   quota;
        int   len;
        int   sent_at_start;
        logic [7:0]  w;
        logic [19:0] v;
        gap_pcts = '{0, 56, 36, 0, 56, 36};
        caps = '{255, $urandom_range(2, 254), 1, $urandom_range(2, 254),
                 $urandom_range(2, 254), 17};
        quota = 52;
        for (int p = 0; p < 6; p++)
        begin
            set_capacity(8'(caps[p]));
            sent_at_start = n_requests;
            while (n_requests - sent_at_start < quota)
            begin
                // mostly sets that fit the store, now and then an overfull one
                len = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(7) == 0)
                        w = 8'($urandom());
                    else
                        w = 8'($urandom_range(0, int'(cap_setting) / 3 + 1));
                    case ($urandom_range(3))
                        0: v = 20'($urandom());
                        1: v = 20'($urandom_range(0, 3));
                        default: v = 20'($urandom_range(0, 1000));
                    endcase
                    send_request(make_req(w, v, k == len - 1), gap_pcts[p]);
                end
                // hold off until the solver has drained, now and then
                if ($urandom_range(5) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        item         = '0;
        cap_setting  = ks01_pkg::CAPACITY_RESET;
        stored_count = 0;
        n_errors     = 0;
        n_requests   = 0;
        n_solves     = 0;
        n_results    = 0;
        n_settings   = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_capacity_reset();
        test_nothing_fits();
        test_tie();
        test_zero_weight();
        test_full_store();
        test_random_sets();

        wait_drained();
        // leave room for any stray result
        repeat (100) @(negedge clk);
        $display("Run covered %0d requests in %0d solves, %0d results checked,",
                 n_requests, n_solves, n_results);
        $display("across %0d capacity settings with and without sender gaps.", n_settings);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Stop a hung run after 50 ms
    initial
    begin
        #(64'd50_000_000);
        $display("Timeout with %0d picks pending", expected_picks.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
